// ----- hw/rtl/tsi_pkg.sv -----
// ----------------------------------------------------------------------------
// tsi_pkg
// Types, codes and arithmetic helpers for the turtle symbol interpreter.
// ----------------------------------------------------------------------------
package tsi_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  localparam int COORD_W = 32;
  localparam int COEF_W  = 18;
  localparam int REG_W   = 3;

  localparam logic [REG_W-1:0] REG_LEFT_COS  = 3'd0;
  localparam logic [REG_W-1:0] REG_LEFT_SIN  = 3'd1;
  localparam logic [REG_W-1:0] REG_RIGHT_COS = 3'd2;
  localparam logic [REG_W-1:0] REG_RIGHT_SIN = 3'd3;
  localparam logic [REG_W-1:0] REG_REVERSE   = 3'd4;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SYMBOL = 1'b1;

  localparam logic [7:0] SYM_DRAW_F = 8'h46;  // F
  localparam logic [7:0] SYM_DRAW_G = 8'h47;  // G
  localparam logic [7:0] SYM_MOVE   = 8'h66;  // f
  localparam logic [7:0] SYM_LEFT   = 8'h2B;  // +
  localparam logic [7:0] SYM_RIGHT  = 8'h2D;  // -
  localparam logic [7:0] SYM_TURN   = 8'h7C;  // |
  localparam logic [7:0] SYM_PUSH   = 8'h5B;  // [
  localparam logic [7:0] SYM_POP    = 8'h5D;  // ]

  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 136;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  // full turtle state, pos_x in the lowest bits
  typedef struct packed {
    coord_t prev_y;
    coord_t prev_x;
    coord_t dir_y;
    coord_t dir_x;
    coord_t pos_y;
    coord_t pos_x;
  } turtle_t;

  localparam int ENTRY_W = $bits(turtle_t);

  typedef struct packed {
    logic    stack_overflow;
    coord_t  old_y;
    coord_t  old_x;
    coord_t  y;
    coord_t  x;
  } result_t;

  typedef struct packed {
    logic    clear;
    logic    push;
    logic    pop;
    turtle_t data;
  } stack_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stack_stat_t;

  function automatic coord_t sat33(input logic signed [COORD_W:0] v);
    coord_t r;
    if (v[COORD_W] != v[COORD_W-1]) begin
      r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // a*p -/+ b*q, rounded half up at bit 16, saturated
  function automatic coord_t rot_axis(input coef_t a, input coord_t p,
                                      input coef_t b, input coord_t q,
                                      input logic subtract);
    logic signed [COORD_W+COEF_W-1:0] p1;
    logic signed [COORD_W+COEF_W-1:0] p2;
    logic signed [COORD_W+COEF_W:0]   acc;
    logic signed [COORD_W+COEF_W:0]   shf;
    logic signed [COORD_W+2:0]        sh;
    coord_t r;
    p1 = a * p;
    p2 = b * q;
    acc = subtract ? (p1 - p2) : (p1 + p2);
    acc = acc + (COORD_W+COEF_W+1)'(32768);
    shf = acc >>> 16;
    sh = shf[COORD_W+2:0];
    if (sh > (COORD_W+3)'(signed'(33'sh0_7FFF_FFFF))) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (sh < -(COORD_W+3)'(signed'(33'sh0_8000_0000))) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = sh[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/turtle_symbol_interpreter_top.sv -----
// ----------------------------------------------------------------------------
// turtle_symbol_interpreter_top
// L-system turtle interpreter: one symbol byte per beat, Q16.16 vertices out.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    symbol, start point/vector, command
//  m_*       out  m_tvalid/m_tready    vertex, old vertex, overflow flag
//  cfg_*     in   cfg_we               turn matrices, reverse mode
//
// One beat per cycle while s_tready is high; every symbol finishes in the cycle it is taken.
// The turn path (two 32x18 multiplies and an add per axis) and the stack
// top-of-stack / RAM read loop set the cycle time.
// Reset is synchronous; no clearing pass, the stack RAM is only read after
// being written. s_tready drops only while the skid stage holds a beat.
// ----------------------------------------------------------------------------
module turtle_symbol_interpreter_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // symbol[7:0], start_x[39:8], start_y[71:40], start_dx[103:72],
  // start_dy[135:104], keep_old[136], zero pad
  input  logic [143:0] s_tdata,
  // command[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // x[31:0], y[63:32], old_x[95:64], old_y[127:96], stack_overflow[128], pad
  output logic [135:0] m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [17:0]  cfg_data
);

  tsi_pkg::coef_t left_cos;
  tsi_pkg::coef_t left_sin;
  tsi_pkg::coef_t right_cos;
  tsi_pkg::coef_t right_sin;
  logic           reverse_mode;

  tsi_pkg::turtle_t     st;
  tsi_pkg::turtle_t     st_next;
  logic                 overflow_seen;
  logic                 overflow_next;
  tsi_pkg::stack_cmd_t  scmd;
  tsi_pkg::turtle_t     tos;
  tsi_pkg::stack_stat_t sstat;
  tsi_pkg::result_t     res;
  tsi_pkg::result_t     out_res;
  logic                 res_valid;
  logic                 emit;
  logic                 accept;

  logic                 command;
  logic [7:0]           symbol;
  tsi_pkg::coord_t      start_x;
  tsi_pkg::coord_t      start_y;
  tsi_pkg::coord_t      start_dx;
  tsi_pkg::coord_t      start_dy;
  logic                 keep_old;

  tsi_pkg::coord_t      step_x;
  tsi_pkg::coord_t      step_y;
  tsi_pkg::coord_t      rot_x;
  tsi_pkg::coord_t      rot_y;
  tsi_pkg::coef_t       c_sel;
  tsi_pkg::coef_t       s_sel;
  logic                 use_left;

  assign command  = s_tuser[0];
  assign symbol   = s_tdata[7:0];
  assign start_x  = s_tdata[39:8];
  assign start_y  = s_tdata[71:40];
  assign start_dx = s_tdata[103:72];
  assign start_dy = s_tdata[135:104];
  assign keep_old = s_tdata[136];

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_cos     <= tsi_pkg::COEF_W'(65536);
      left_sin     <= '0;
      right_cos    <= tsi_pkg::COEF_W'(65536);
      right_sin    <= '0;
      reverse_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tsi_pkg::REG_LEFT_COS:  left_cos     <= cfg_data;
        tsi_pkg::REG_LEFT_SIN:  left_sin     <= cfg_data;
        tsi_pkg::REG_RIGHT_COS: right_cos    <= cfg_data;
        tsi_pkg::REG_RIGHT_SIN: right_sin    <= cfg_data;
        tsi_pkg::REG_REVERSE:   reverse_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // step and turn units
  always_comb begin
    if (reverse_mode) begin
      step_x = tsi_pkg::sat33({st.pos_x[31], st.pos_x} - {st.dir_x[31], st.dir_x});
      step_y = tsi_pkg::sat33({st.pos_y[31], st.pos_y} - {st.dir_y[31], st.dir_y});
    end else begin
      step_x = tsi_pkg::sat33({st.pos_x[31], st.pos_x} + {st.dir_x[31], st.dir_x});
      step_y = tsi_pkg::sat33({st.pos_y[31], st.pos_y} + {st.dir_y[31], st.dir_y});
    end
  end

  assign use_left = (symbol == tsi_pkg::SYM_LEFT) ^ reverse_mode;
  assign c_sel    = use_left ? left_cos : right_cos;
  assign s_sel    = use_left ? left_sin : right_sin;
  assign rot_x    = tsi_pkg::rot_axis(c_sel, st.dir_x, s_sel, st.dir_y, 1'b1);
  assign rot_y    = tsi_pkg::rot_axis(s_sel, st.dir_x, c_sel, st.dir_y, 1'b0);

  always_comb begin
    st_next       = st;
    overflow_next = overflow_seen;
    emit          = 1'b0;
    scmd.clear    = 1'b0;
    scmd.push     = 1'b0;
    scmd.pop      = 1'b0;
    scmd.data     = st;
    if (command == tsi_pkg::CMD_START) begin
      st_next.prev_x = keep_old ? st.pos_x : start_x;
      st_next.prev_y = keep_old ? st.pos_y : start_y;
      st_next.pos_x  = start_x;
      st_next.pos_y  = start_y;
      st_next.dir_x  = start_dx;
      st_next.dir_y  = start_dy;
      scmd.clear     = 1'b1;
      emit           = 1'b1;
    end else begin
      case (symbol)
        tsi_pkg::SYM_DRAW_F, tsi_pkg::SYM_DRAW_G, tsi_pkg::SYM_MOVE: begin
          st_next.prev_x = st.pos_x;
          st_next.prev_y = st.pos_y;
          st_next.pos_x  = step_x;
          st_next.pos_y  = step_y;
          emit           = (symbol != tsi_pkg::SYM_MOVE);
        end
        tsi_pkg::SYM_LEFT, tsi_pkg::SYM_RIGHT: begin
          st_next.dir_x = rot_x;
          st_next.dir_y = rot_y;
        end
        tsi_pkg::SYM_TURN: begin
          st_next.dir_x = tsi_pkg::sat33(-{st.dir_x[31], st.dir_x});
          st_next.dir_y = tsi_pkg::sat33(-{st.dir_y[31], st.dir_y});
        end
        tsi_pkg::SYM_PUSH: begin
          scmd.push = 1'b1;
          if (sstat.full) begin
            overflow_next = 1'b1;
          end
        end
        tsi_pkg::SYM_POP: begin
          scmd.pop = 1'b1;
          if (!sstat.empty) begin
            st_next = tos;
          end
        end
        default: ;
      endcase
    end
    if (!accept) begin
      scmd.clear = 1'b0;
      scmd.push  = 1'b0;
      scmd.pop   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      st            <= st_next;
      overflow_seen <= overflow_next;
    end
  end

  tsi_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (scmd),
    .tos  (tos),
    .stat (sstat)
  );

  assign res.x              = st_next.pos_x;
  assign res.y              = st_next.pos_y;
  assign res.old_x          = st_next.prev_x;
  assign res.old_y          = st_next.prev_y;
  assign res.stack_overflow = overflow_next;
  assign res_valid          = accept && emit;

  tsi_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {7'b0, out_res};

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    accept && command == tsi_pkg::CMD_START |=> sstat.empty)
    else $error("start did not empty the stack");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |=> overflow_seen)
    else $error("overflow flag cleared");

  a_pop_restores: assert property (@(posedge clk) disable iff (rst)
    accept && command == tsi_pkg::CMD_SYMBOL && symbol == tsi_pkg::SYM_POP && !sstat.empty
    |=> st == $past(tos))
    else $error("pop did not restore saved state");

endmodule

// ----- hw/rtl/tsi_ram.sv -----
// ----------------------------------------------------------------------------
// tsi_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/tsi_stack.sv -----
// ----------------------------------------------------------------------------
// tsi_stack
// State stack: top entry in a register, the rest in RAM. The entry below the
// top is read every cycle so a pop takes its new top without waiting on the RAM.
// ----------------------------------------------------------------------------
module tsi_stack (
  input  logic                 clk,
  input  logic                 rst,
  input  tsi_pkg::stack_cmd_t  cmd,
  output tsi_pkg::turtle_t     tos,
  output tsi_pkg::stack_stat_t stat
);

  logic [tsi_pkg::CNT_W-1:0]  count;
  logic [tsi_pkg::CNT_W-1:0]  count_next;
  logic [tsi_pkg::CNT_W-1:0]  cnt_m1;
  logic [tsi_pkg::CNT_W-1:0]  cnt_m2;
  logic                       do_push;
  logic                       do_pop;
  logic                       wr_en;
  logic [tsi_pkg::ADDR_W-1:0] wr_addr;
  logic [tsi_pkg::ADDR_W-1:0] rd_addr;
  logic [tsi_pkg::ENTRY_W-1:0] rd_data;
  logic                       fwd_valid;
  tsi_pkg::turtle_t           fwd_data;
  tsi_pkg::turtle_t           below;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == tsi_pkg::CNT_W'(tsi_pkg::STACK_DEPTH));

  assign do_push = cmd.push && !stat.full;
  assign do_pop  = cmd.pop && !stat.empty;

  always_comb begin
    count_next = count;
    if (cmd.clear) begin
      count_next = '0;
    end else if (do_push) begin
      count_next = count + tsi_pkg::CNT_W'(1);
    end else if (do_pop) begin
      count_next = count - tsi_pkg::CNT_W'(1);
    end
  end

  assign cnt_m1  = count - tsi_pkg::CNT_W'(1);
  assign cnt_m2  = count_next - tsi_pkg::CNT_W'(2);
  assign wr_en   = do_push && !stat.empty;
  assign wr_addr = cnt_m1[tsi_pkg::ADDR_W-1:0];
  assign rd_addr = cnt_m2[tsi_pkg::ADDR_W-1:0];

  tsi_ram #(
    .WIDTH (tsi_pkg::ENTRY_W),
    .DEPTH (tsi_pkg::STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (tos),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign below = fwd_valid ? fwd_data : tsi_pkg::turtle_t'(rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      fwd_valid <= 1'b0;
    end else begin
      count     <= count_next;
      fwd_valid <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= tos;
    if (!cmd.clear) begin
      if (do_push) begin
        tos <= cmd.data;
      end else if (do_pop) begin
        tos <= below;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= tsi_pkg::CNT_W'(tsi_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    do_push && !cmd.clear |=> count == $past(count) + tsi_pkg::CNT_W'(1))
    else $error("push did not advance count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    do_pop && !cmd.push && !cmd.clear |=> count == $past(count) - tsi_pkg::CNT_W'(1))
    else $error("pop did not retire count");

endmodule

// ----- hw/rtl/tsi_obuf.sv -----
// ----------------------------------------------------------------------------
// tsi_obuf
// Output register with a skid stage; input ready is a register.
// ----------------------------------------------------------------------------
module tsi_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  tsi_pkg::result_t  in_data,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tsi_pkg::result_t  out_data
);

  logic             skid_valid;
  tsi_pkg::result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (in_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (in_valid) begin
        skid_data <= in_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (in_valid) begin
      out_data <= in_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output is empty");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !in_valid)
    else $error("beat offered while skid is full");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && !skid_valid)
    else $error("skid beat not moved to output");

endmodule
